[rtl/bis_pkg.sv]
// ============================================================================
// bis_pkg: shared types and constants of the bilinear image scaler
// Widths, register indexes, datapath commands and the blend function.
// ============================================================================
package bis_pkg;

    localparam int MAX_SRC_WIDTH  = 512;
    localparam int MAX_SRC_HEIGHT = 512;
    localparam int FRAC_BITS      = 8;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int AREA_W      = $clog2(STORE_DEPTH + 1);
    localparam int SW_W        = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W        = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int XI_W        = $clog2(MAX_SRC_WIDTH);
    localparam int YI_W        = $clog2(MAX_SRC_HEIGHT);

    localparam int SRC_DIM_W  = 10;
    localparam int DST_DIM_W  = 13;
    localparam int SCALE_W    = 25;
    localparam int COORD_W    = 12;
    localparam int MAX_DST    = 4096;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = COORD_W + SCALE_W;
    localparam int INT_W      = POS_W - FRAC_W;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int WSCALE     = 1 << FRAC_BITS;
    localparam int BL_W       = CH_W + FRAC_BITS + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 3'd5;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EMIT = 1'b1;

    typedef enum logic [1:0] {
        CORNER_TL,
        CORNER_TR,
        CORNER_BL,
        CORNER_BR
    } corner_t;

    typedef struct packed {
        logic    ld_we;
        logic    pos_en;
        logic    loc_en;
        logic    base_en;
        logic    rd_en;
        corner_t corner;
        logic    cap_p0;
        logic    ld_top;
        logic    ld_bot;
        logic    fin;
    } bis_cmd_t;

    typedef struct packed {
        logic out_busy;
    } bis_stat_t;

    // (p*(S-w) + q*w + S/2) >> FRAC_BITS
    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] p,
                                              input logic [CH_W-1:0] q,
                                              input logic [FRAC_BITS-1:0] w);
        logic [BL_W-1:0] acc;
        acc = BL_W'(p) * (BL_W'(WSCALE) - BL_W'(w)) + BL_W'(q) * BL_W'(w)
              + BL_W'(WSCALE / 2);
        return acc[FRAC_BITS +: CH_W];
    endfunction

endpackage

[rtl/bis_stream_if.sv]
// ============================================================================
// bis_stream_if: valid/ready channels of the bilinear image scaler
// Input channel carries load/emit items, output channel carries pixels.
// ============================================================================
interface bis_in_if;
    import bis_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;

    modport source (output valid, kind, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, kind, in_blue, in_green, in_red, output ready);
endinterface

interface bis_out_if;
    import bis_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_blue;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_red;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               frame_end;

    modport source (output valid, out_blue, out_green, out_red, out_col, out_row,
                    frame_end, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, out_col, out_row,
                    frame_end, output ready);
endinterface

[rtl/bilinear_image_scaler.sv]
// ============================================================================
// bilinear_image_scaler: three-channel bilinear image resizer
// Loads source pixels into a frame store, emits destination pixels in raster
// order by bilinear interpolation of four neighbors.
// ============================================================================
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   kind, in_blue, in_green, in_red
//  out_ch   out  valid/ready   out_blue, out_green, out_red, out_col, out_row,
//                              frame_end
//  cfg      in   cfg_we        cfg_index, cfg_data
//
//  Load beat: written straight into the frame store.
//  Emit beat: accepted only when idle; it runs through the position multiply,
//  row base multiply and four serial reads of the single-port store.
//  Reset sets control, counters and config; the store holds garbage until loaded.
//  A finished pixel waits in the output register; a further emit stalls only
//  at its final step while that register is full and not being taken.
// ============================================================================
module bilinear_image_scaler (
    input  logic                           clk,
    input  logic                           rst_n,
    bis_in_if.sink                         in_ch,
    bis_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bis_pkg::*;

    bis_cmd_t  cmd;
    bis_stat_t stat;
    logic      in_ready;

    bis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bis_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_blue   (in_ch.in_blue),
        .in_green  (in_ch.in_green),
        .in_red    (in_ch.in_red),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_blue  (out_ch.out_blue),
        .out_green (out_ch.out_green),
        .out_red   (out_ch.out_red),
        .out_col   (out_ch.out_col),
        .out_row   (out_ch.out_row),
        .frame_end (out_ch.frame_end)
    );

    assign in_ch.ready = in_ready;
endmodule

[rtl/bis_ram.sv]
// ============================================================================
// bis_ram: generic single-port RAM
// One access per cycle, registered read data.
// ============================================================================
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end
endmodule

[rtl/bis_ctrl.sv]
// ============================================================================
// bis_ctrl: controller of the bilinear image scaler
// Sequences load writes and, per emit, position, address, four corner reads, blends and output load.
// ============================================================================
module bis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    output logic                in_ready,
    input  bis_pkg::bis_stat_t  stat,
    output bis_pkg::bis_cmd_t   cmd
);
    import bis_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_LOC,
        ST_BASE,
        ST_RD_TL,
        ST_RD_TR,
        ST_RD_BL,
        ST_RD_BR,
        ST_BOT,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        cmd           = '0;
        cmd.corner    = CORNER_TL;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    if (in_kind == KIND_EMIT)
                    begin
                        state_next    = ST_POS;
                        in_ready_next = 1'b0;
                    end
                    else
                    begin
                        cmd.ld_we = 1'b1;
                    end
                end
            end
            ST_POS:
            begin
                cmd.pos_en = 1'b1;
                state_next = ST_LOC;
            end
            ST_LOC:
            begin
                cmd.loc_en = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base_en = 1'b1;
                state_next  = ST_RD_TL;
            end
            ST_RD_TL:
            begin
                cmd.rd_en  = 1'b1;
                cmd.corner = CORNER_TL;
                state_next = ST_RD_TR;
            end
            ST_RD_TR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.corner = CORNER_TR;
                cmd.cap_p0 = 1'b1;
                state_next = ST_RD_BL;
            end
            ST_RD_BL:
            begin
                cmd.rd_en  = 1'b1;
                cmd.corner = CORNER_BL;
                cmd.ld_top = 1'b1;
                state_next = ST_RD_BR;
            end
            ST_RD_BR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.corner = CORNER_BR;
                cmd.cap_p0 = 1'b1;
                state_next = ST_BOT;
            end
            ST_BOT:
            begin
                cmd.ld_bot = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.fin       = 1'b1;
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    assign in_ready = in_ready_reg;
endmodule

[rtl/bis_datapath.sv]
// ============================================================================
// bis_datapath: datapath of the bilinear image scaler
// Config registers, counters, frame store, position math, blend, output beat.
// ============================================================================
module bis_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [bis_pkg::CH_W-1:0]          in_blue,
    input  logic [bis_pkg::CH_W-1:0]          in_green,
    input  logic [bis_pkg::CH_W-1:0]          in_red,
    input  bis_pkg::bis_cmd_t                 cmd,
    output bis_pkg::bis_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bis_pkg::CH_W-1:0]          out_blue,
    output logic [bis_pkg::CH_W-1:0]          out_green,
    output logic [bis_pkg::CH_W-1:0]          out_red,
    output logic [bis_pkg::COORD_W-1:0]       out_col,
    output logic [bis_pkg::COORD_W-1:0]       out_row,
    output logic                              frame_end
);
    import bis_pkg::*;

    logic [SRC_DIM_W-1:0] src_width_reg, src_height_reg;
    logic [DST_DIM_W-1:0] dst_width_reg, dst_height_reg;
    logic [SCALE_W-1:0]   scale_x_reg, scale_y_reg;

    logic [ADDR_W-1:0]    load_idx_reg, load_idx_next;
    logic [COORD_W-1:0]   col_reg, col_next, row_reg, row_next;

    logic [POS_W-1:0]     pos_x_reg, pos_y_reg;
    logic [XI_W-1:0]      x1_reg, x2_reg, x1_next, x2_next;
    logic [YI_W-1:0]      y1_reg, y2_reg, y1_next, y2_next;
    logic [FRAC_BITS-1:0] a_reg, b_reg;
    logic [ADDR_W-1:0]    base1_reg, base2_reg;
    logic [PIX_W-1:0]     p0_reg, top_reg, bot_reg, hblend;

    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     out_pix_reg, vblend;
    logic [COORD_W-1:0]   out_col_reg, out_row_reg;
    logic                 out_end_reg;

    logic [SW_W-1:0]      sw;
    logic [SH_W-1:0]      sh;
    logic [DST_DIM_W-1:0] dw, dh;
    logic [AREA_W-1:0]    area;
    logic [INT_W-1:0]     ip_x, ip_y, lim_x, lim_y;
    logic                 last_row_pixel, last;

    logic                 ram_en, ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [PIX_W-1:0]     ram_rdata;

    // clamped sizes
    always_comb
    begin
        if (src_width_reg == '0)
            sw = SW_W'(1);
        else if (DST_DIM_W'(src_width_reg) > DST_DIM_W'(MAX_SRC_WIDTH))
            sw = SW_W'(MAX_SRC_WIDTH);
        else
            sw = SW_W'(src_width_reg);

        if (src_height_reg == '0)
            sh = SH_W'(1);
        else if (DST_DIM_W'(src_height_reg) > DST_DIM_W'(MAX_SRC_HEIGHT))
            sh = SH_W'(MAX_SRC_HEIGHT);
        else
            sh = SH_W'(src_height_reg);

        if (dst_width_reg == '0)
            dw = DST_DIM_W'(1);
        else if (dst_width_reg > DST_DIM_W'(MAX_DST))
            dw = DST_DIM_W'(MAX_DST);
        else
            dw = dst_width_reg;

        if (dst_height_reg == '0)
            dh = DST_DIM_W'(1);
        else if (dst_height_reg > DST_DIM_W'(MAX_DST))
            dh = DST_DIM_W'(MAX_DST);
        else
            dh = dst_height_reg;
    end

    assign area = AREA_W'(sw) * AREA_W'(sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_DIM_W'(512);
            src_height_reg <= SRC_DIM_W'(512);
            dst_width_reg  <= DST_DIM_W'(512);
            dst_height_reg <= DST_DIM_W'(512);
            scale_x_reg    <= SCALE_W'(65536);
            scale_y_reg    <= SCALE_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_DIM_W-1:0];
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_DIM_W-1:0];
                CFG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_DIM_W-1:0];
                CFG_SCALE_X:    scale_x_reg    <= cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:    scale_y_reg    <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // load index and emit counters
    always_comb
    begin
        if (AREA_W'(load_idx_reg) + AREA_W'(1) >= area)
            load_idx_next = '0;
        else
            load_idx_next = load_idx_reg + ADDR_W'(1);

        last_row_pixel = (DST_DIM_W'(col_reg) + DST_DIM_W'(1) >= dw);
        last           = last_row_pixel && (DST_DIM_W'(row_reg) + DST_DIM_W'(1) >= dh);

        if (last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (last_row_pixel)
        begin
            col_next = '0;
            row_next = row_reg + COORD_W'(1);
        end
        else
        begin
            col_next = col_reg + COORD_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (cmd.ld_we)
                load_idx_reg <= load_idx_next;
            if (cmd.fin)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // neighbor location
    always_comb
    begin
        ip_x  = pos_x_reg[POS_W-1:FRAC_W];
        ip_y  = pos_y_reg[POS_W-1:FRAC_W];
        lim_x = INT_W'(sw) - INT_W'(1);
        lim_y = INT_W'(sh) - INT_W'(1);

        x1_next = (ip_x > lim_x) ? lim_x[XI_W-1:0] : ip_x[XI_W-1:0];
        y1_next = (ip_y > lim_y) ? lim_y[YI_W-1:0] : ip_y[YI_W-1:0];

        if (SW_W'(x1_next) + SW_W'(1) < sw)
            x2_next = x1_next + XI_W'(1);
        else
            x2_next = lim_x[XI_W-1:0];
        if (SH_W'(y1_next) + SH_W'(1) < sh)
            y2_next = y1_next + YI_W'(1);
        else
            y2_next = lim_y[YI_W-1:0];
    end

    // frame store port
    always_comb
    begin
        ram_we = cmd.ld_we;
        ram_en = cmd.ld_we || cmd.rd_en;
        if (cmd.ld_we)
            ram_addr = load_idx_reg;
        else
        begin
            case (cmd.corner)
                CORNER_TL: ram_addr = base1_reg + ADDR_W'(x1_reg);
                CORNER_TR: ram_addr = base1_reg + ADDR_W'(x2_reg);
                CORNER_BL: ram_addr = base2_reg + ADDR_W'(x1_reg);
                CORNER_BR: ram_addr = base2_reg + ADDR_W'(x2_reg);
                default:   ram_addr = base1_reg + ADDR_W'(x1_reg);
            endcase
        end
    end

    bis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({in_red, in_green, in_blue}),
        .rdata (ram_rdata)
    );

    // horizontal blend of held pixel with arriving pixel, vertical blend of rows
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            hblend[ch*CH_W +: CH_W] = blend(p0_reg[ch*CH_W +: CH_W],
                                            ram_rdata[ch*CH_W +: CH_W], a_reg);
            vblend[ch*CH_W +: CH_W] = blend(top_reg[ch*CH_W +: CH_W],
                                            bot_reg[ch*CH_W +: CH_W], b_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_en)
        begin
            pos_x_reg <= POS_W'(col_reg) * POS_W'(scale_x_reg);
            pos_y_reg <= POS_W'(row_reg) * POS_W'(scale_y_reg);
        end
        if (cmd.loc_en)
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            y1_reg <= y1_next;
            y2_reg <= y2_next;
            a_reg  <= pos_x_reg[FRAC_W-1 -: FRAC_BITS];
            b_reg  <= pos_y_reg[FRAC_W-1 -: FRAC_BITS];
        end
        if (cmd.base_en)
        begin
            base1_reg <= ADDR_W'(y1_reg) * ADDR_W'(sw);
            base2_reg <= ADDR_W'(y2_reg) * ADDR_W'(sw);
        end
        if (cmd.cap_p0)
            p0_reg <= ram_rdata;
        if (cmd.ld_top)
            top_reg <= hblend;
        if (cmd.ld_bot)
            bot_reg <= hblend;
        if (cmd.fin)
        begin
            out_pix_reg <= vblend;
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
            out_end_reg <= last;
        end
    end

    // output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_blue  = out_pix_reg[0*CH_W +: CH_W];
    assign out_green = out_pix_reg[1*CH_W +: CH_W];
    assign out_red   = out_pix_reg[2*CH_W +: CH_W];
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign frame_end = out_end_reg;
endmodule

[rtl/bis_checker.sv]
// ============================================================================
// bis_checker: port-level checks of the bilinear image scaler
// Output beat ordering in raster order and output valid held under stall.
// ============================================================================
module bis_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bis_pkg::COORD_W-1:0]  out_col,
    input logic [bis_pkg::COORD_W-1:0]  out_row,
    input logic                         frame_end
);
    import bis_pkg::*;

    logic               out_fire;
    logic               seen_reg;
    logic [COORD_W-1:0] last_col_reg, last_row_reg;
    logic               last_end_reg;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_col_reg <= '0;
            last_row_reg <= '0;
            last_end_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            seen_reg     <= 1'b1;
            last_col_reg <= out_col;
            last_row_reg <= out_row;
            last_end_reg <= frame_end;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg && out_col != '0 |->
            out_col == last_col_reg + COORD_W'(1) && out_row == last_row_reg)
        else $error("column did not advance by one");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg && out_col == '0 && out_row != '0 |->
            out_row == last_row_reg + COORD_W'(1) && !last_end_reg)
        else $error("row did not advance by one");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg && last_end_reg |-> out_col == '0 && out_row == '0)
        else $error("frame did not restart at origin");
endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_col   (out_ch.out_col),
    .out_row   (out_ch.out_row),
    .frame_end (out_ch.frame_end)
);
